@@ rtl/rcd_pkg.sv @@
// Shared constants and types for the radix digit converter.
`timescale 1ns / 1ps

package rcd_pkg;

  localparam int VALUE_W    = 31;
  localparam int BASE_W     = 8;
  localparam int DIGIT_W    = 8;
  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int STEP_W     = $clog2(VALUE_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KICK,
    ST_WAIT,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/radix_convert_digits_top.sv @@
// Top level of the radix digit converter: sequencer, digit stack and result registers.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive value and base and raise start; the command is
//   transferred at a rising edge where start is high and busy is low.
//   busy stays high from the cycle after the transfer until the last digit
//   has been placed on the result ports.
//   Result channel: each digit appears for exactly one cycle with strobe
//   high, most significant digit first; last marks the final digit and
//   truncated is set on every digit when high digits were dropped.
//   A base below two yields one result (digit 0, bad_base 1, last 1) in the
//   cycle after the transfer, and the block never goes busy.
//   Every digit costs one pass of the shared serial divider (one quotient
//   bit per cycle, plus kick and push); then every digit is popped through
//   a stack read and a result register. The worst case is 31 binary digits.
//   Reset clears the sequencer and the result strobe; the digit stack needs
//   no clearing since only entries written in the current conversion are read.
//   The receiver cannot stall: results are never held back.
module radix_convert_digits_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rcd_pkg::VALUE_W-1:0] value,
  input  logic [rcd_pkg::BASE_W-1:0]  base,
  output logic                        busy,
  output logic                        strobe,
  output logic [rcd_pkg::DIGIT_W-1:0] digit,
  output logic                        last,
  output logic                        bad_base,
  output logic                        truncated
);

  rcd_pkg::state_t state, state_next;

  logic [rcd_pkg::VALUE_W-1:0] quotient;
  logic [rcd_pkg::BASE_W-1:0]  base_reg;
  logic [rcd_pkg::CNT_W-1:0]   count;
  logic                        trunc;

  logic                        div_start;
  logic                        div_done;
  logic [rcd_pkg::VALUE_W-1:0] div_quo;
  logic [rcd_pkg::BASE_W-1:0]  div_rem;

  logic                        push;
  logic                        stack_full;
  logic                        rd_en;
  logic [rcd_pkg::ADDR_W-1:0]  rd_addr;
  logic [rcd_pkg::DIGIT_W-1:0] rd_data;
  logic [rcd_pkg::DIGIT_W-1:0] stack [rcd_pkg::MAX_DIGITS];

  logic                        accept;
  logic                        base_ok;

  assign accept     = start && !busy;
  assign base_ok    = (base >= rcd_pkg::BASE_W'(2));
  assign stack_full = (count >= rcd_pkg::CNT_W'(rcd_pkg::MAX_DIGITS));
  assign rd_addr    = rcd_pkg::ADDR_W'(count - 1'b1);
  assign busy       = (state != rcd_pkg::ST_IDLE);

  rcd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (quotient),
    .divisor   (base_reg),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: kick the divider, wait for a digit, push it (or drop it when the
  // stack is full), repeat until the quotient is zero; then pop via READ and EMIT.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    push       = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      rcd_pkg::ST_IDLE: begin
        if (accept && base_ok) state_next = rcd_pkg::ST_KICK;
      end
      rcd_pkg::ST_KICK: begin
        div_start  = 1'b1;
        state_next = rcd_pkg::ST_WAIT;
      end
      rcd_pkg::ST_WAIT: begin
        if (div_done) begin
          push       = !stack_full;
          state_next = (div_quo == '0) ? rcd_pkg::ST_READ : rcd_pkg::ST_KICK;
        end
      end
      rcd_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = rcd_pkg::ST_EMIT;
      end
      rcd_pkg::ST_EMIT: begin
        state_next = (count == '0) ? rcd_pkg::ST_IDLE : rcd_pkg::ST_READ;
      end
      default: state_next = rcd_pkg::ST_IDLE;
    endcase
  end

  // Digit stack: write at the fill count, registered read at the top.
  always_ff @(posedge clk) begin
    if (push) stack[count[rcd_pkg::ADDR_W-1:0]] <= div_rem;
    if (rd_en) rd_data <= stack[rd_addr];
  end

  // Conversion bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      trunc <= 1'b0;
    end else begin
      if (accept) begin
        count <= '0;
        trunc <= 1'b0;
      end else if (state == rcd_pkg::ST_WAIT && div_done) begin
        if (stack_full) begin
          trunc <= 1'b1;      // drop the more significant digit
        end else begin
          count <= count + 1'b1;
        end
      end else if (rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Running quotient and latched base.
  always_ff @(posedge clk) begin
    if (accept) begin
      quotient <= value;
      base_reg <= base;
    end else if (state == rcd_pkg::ST_WAIT && div_done) begin
      quotient <= div_quo;
    end
  end

  // Result registers: one-cycle strobe per digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && !base_ok) || (state == rcd_pkg::ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !base_ok) begin
      digit     <= '0;
      last      <= 1'b1;
      bad_base  <= 1'b1;
      truncated <= 1'b0;
    end else if (state == rcd_pkg::ST_EMIT) begin
      digit     <= rd_data;
      last      <= (count == '0);
      bad_base  <= 1'b0;
      truncated <= trunc;
    end
  end

endmodule

@@ rtl/rcd_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module rcd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rcd_pkg::VALUE_W-1:0] dividend,
  input  logic [rcd_pkg::BASE_W-1:0]  divisor,
  output logic                        done,
  output logic [rcd_pkg::VALUE_W-1:0] quotient,
  output logic [rcd_pkg::BASE_W-1:0]  remainder
);

  logic                        active;
  logic [rcd_pkg::STEP_W-1:0]  step;
  logic [rcd_pkg::VALUE_W-1:0] quo;
  logic [rcd_pkg::BASE_W-1:0]  rem;
  logic [rcd_pkg::BASE_W-1:0]  rem_next;
  logic [rcd_pkg::BASE_W:0]    trial;
  logic                        qbit;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial    = {rem, quo[rcd_pkg::VALUE_W-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? rcd_pkg::BASE_W'(trial - {1'b0, divisor})
                    : trial[rcd_pkg::BASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        if (step == rcd_pkg::STEP_W'(rcd_pkg::VALUE_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[rcd_pkg::VALUE_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ tb/sv/radix_convert_digits_checker.sv @@
// Checker for the radix digit converter: predicts the digit stream of each transfer and compares.
`timescale 1ns / 1ps

module radix_convert_digits_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rcd_pkg::VALUE_W-1:0] value,
  input  logic [rcd_pkg::BASE_W-1:0]  base,
  input  logic                        strobe,
  input  logic [rcd_pkg::DIGIT_W-1:0] digit,
  input  logic                        last,
  input  logic                        bad_base,
  input  logic                        truncated,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [rcd_pkg::DIGIT_W-1:0] digit;
    logic                        last;
    logic                        bad_base;
    logic                        truncated;
  } digit_rec_t;

  digit_rec_t expected_digits[$];

  // Divide down to a zero quotient, then queue the stacked remainders top first.
  task automatic predict_digits(input logic [rcd_pkg::VALUE_W-1:0] v,
                                input logic [rcd_pkg::BASE_W-1:0]  b);
    logic [rcd_pkg::DIGIT_W-1:0] stack [rcd_pkg::MAX_DIGITS];
    logic [rcd_pkg::VALUE_W-1:0] quotient;
    int                          depth;
    bit                          dropped;
    digit_rec_t                  rec;
    depth   = 0;
    dropped = 0;
    if (b < 2) begin
      rec = '{digit: '0, last: 1'b1, bad_base: 1'b1, truncated: 1'b0};
      expected_digits.push_back(rec);
      return;
    end
    quotient = v;
    do begin
      if (depth < rcd_pkg::MAX_DIGITS) begin
        stack[depth] = rcd_pkg::DIGIT_W'(quotient % b);
        depth++;
      end else begin
        dropped = 1;
      end
      quotient = quotient / b;
    end while (quotient != 0);
    for (int i = depth - 1; i >= 0; i--) begin
      rec = '{digit: stack[i], last: (i == 0), bad_base: 1'b0, truncated: dropped};
      expected_digits.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    digit_rec_t want;
    if (rst) begin
      expected_digits.delete();
    end else begin
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected result: digit %0d last %0b bad_base %0b truncated %0b",
                 digit, last, bad_base, truncated);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (digit !== want.digit) begin
            $error("digit: expected %0d, actual %0d", want.digit, digit);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errors++;
          end
          if (bad_base !== want.bad_base) begin
            $error("bad_base: expected %0b, actual %0b", want.bad_base, bad_base);
            errors++;
          end
          if (truncated !== want.truncated) begin
            $error("truncated: expected %0b, actual %0b", want.truncated, truncated);
            errors++;
          end
        end
      end
      // Queue the new transfer after retiring results: its digits come later.
      if (start && !busy) predict_digits(value, base);
    end
    pending <= expected_digits.size();
  end

endmodule

@@ tb/sv/radix_convert_digits_top_test.sv @@
// Testbench top for the radix digit converter: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module radix_convert_digits_top_test;

  localparam logic [rcd_pkg::VALUE_W-1:0] VALUE_MAX = {rcd_pkg::VALUE_W{1'b1}};
  localparam int RANDOM_CONVERSIONS = 250;
  // Stop idling for the last stretch so back-to-back transfers get exercised.
  localparam int CALM_TAIL = 50;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic [rcd_pkg::VALUE_W-1:0] value;
  logic [rcd_pkg::BASE_W-1:0]  base;
  logic                        busy;
  logic                        strobe;
  logic [rcd_pkg::DIGIT_W-1:0] digit;
  logic                        last;
  logic                        bad_base;
  logic                        truncated;
  int                          errors;
  int                          pending;

  radix_convert_digits_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .base      (base),
    .busy      (busy),
    .strobe    (strobe),
    .digit     (digit),
    .last      (last),
    .bad_base  (bad_base),
    .truncated (truncated)
  );

  // The checker watches both channels beside the block and keeps the score.
  radix_convert_digits_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .base      (base),
    .strobe    (strobe),
    .digit     (digit),
    .last      (last),
    .bad_base  (bad_base),
    .truncated (truncated),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop: a worst-case run (250 binary conversions of 31 digits, plus
  // gaps) is near 6 ms; allow several times that.
  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Present one command on the falling edge and hold it until the block
  // takes it: the transfer happens at the first rising edge with busy low.
  task automatic convert(input logic [rcd_pkg::VALUE_W-1:0] v,
                         input logic [rcd_pkg::BASE_W-1:0]  b);
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    base  <= b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a burst of cycles; scramble the payload so the block
  // must ignore it while no command is offered.
  task automatic idle_for(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    value <= rcd_pkg::VALUE_W'($urandom);
    base  <= rcd_pkg::BASE_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Mix full-width values with short ones and boundary patterns, so that
  // every bit toggles while most conversions stay short.
  function automatic logic [rcd_pkg::VALUE_W-1:0] pick_value();
    int width;
    width = $urandom_range(1, rcd_pkg::VALUE_W);
    case ($urandom_range(0, 3))
      0: return rcd_pkg::VALUE_W'($urandom);
      1: return rcd_pkg::VALUE_W'($urandom_range(0, 255));
      2: return rcd_pkg::VALUE_W'($urandom) & (VALUE_MAX >> (rcd_pkg::VALUE_W - width));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return VALUE_MAX;
          2: return rcd_pkg::VALUE_W'(1) << (width - 1);
          default: return VALUE_MAX >> (rcd_pkg::VALUE_W - width);
        endcase
      end
    endcase
  endfunction

  // Favor small and ordinary bases; keep a trickle of rejected ones.
  function automatic logic [rcd_pkg::BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9)) inside
      0: return rcd_pkg::BASE_W'($urandom_range(0, 1));
      [1:3]: return rcd_pkg::BASE_W'($urandom_range(2, 16));
      4: begin
        case ($urandom_range(0, 3))
          0: return rcd_pkg::BASE_W'(2);
          1: return rcd_pkg::BASE_W'(128);
          2: return rcd_pkg::BASE_W'(254);
          default: return rcd_pkg::BASE_W'(255);
        endcase
      end
      default: return rcd_pkg::BASE_W'($urandom_range(2, 255));
    endcase
  endfunction

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    base  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero gives one digit, rejected bases, the longest binary
    // result, the widest base, and values around a single base.
    convert('0, rcd_pkg::BASE_W'(2));
    convert('0, rcd_pkg::BASE_W'(10));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(2));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(255));
    convert('0, rcd_pkg::BASE_W'(0));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(1));
    convert(rcd_pkg::VALUE_W'(1), rcd_pkg::BASE_W'(0));
    convert(rcd_pkg::VALUE_W'(12345), rcd_pkg::BASE_W'(10));
    idle_for(3);
    convert(rcd_pkg::VALUE_W'(1), rcd_pkg::BASE_W'(2));
    convert(rcd_pkg::VALUE_W'(254), rcd_pkg::BASE_W'(255));
    convert(rcd_pkg::VALUE_W'(255), rcd_pkg::BASE_W'(255));
    convert(rcd_pkg::VALUE_W'(256), rcd_pkg::BASE_W'(255));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(16));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(3));
    idle_for(1);
    convert(rcd_pkg::VALUE_W'(1) << (rcd_pkg::VALUE_W - 1), rcd_pkg::BASE_W'(2));
    convert(VALUE_MAX, rcd_pkg::BASE_W'(254));
    convert(rcd_pkg::VALUE_W'(32'h2AAA_AAAA), rcd_pkg::BASE_W'(128));
    convert(rcd_pkg::VALUE_W'(32'h5555_5555), rcd_pkg::BASE_W'(2));
    convert(rcd_pkg::VALUE_W'(9), rcd_pkg::BASE_W'(1));
    convert(rcd_pkg::VALUE_W'(9), rcd_pkg::BASE_W'(10));

    // Random: idle bursts between transfers early on, none in the tail.
    for (int n = 0; n < RANDOM_CONVERSIONS; n++) begin
      convert(pick_value(), pick_base());
      if (n < RANDOM_CONVERSIONS - CALM_TAIL && $urandom_range(0, 2) == 0)
        idle_for($urandom_range(1, 19));
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait out the longest conversion; then watch a
    // little longer for stray results.
    for (int n = 0; n < 4000 && pending != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);

    if (pending != 0) $error("%0d expected digits never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
